FILE: rtl/pttq_pkg.sv
// Shared constants, result codes and controller/datapath signal groups of the timer queue.
package pttq_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int TIME_W        = 32;
    localparam int PERIOD_W      = 24;
    localparam int CODE_W        = 2;
    localparam int TID_W         = 3;
    localparam int PERIOD_SCALE  = 10;

    localparam logic [CODE_W-1:0] RC_ADDED = 2'd0;
    localparam logic [CODE_W-1:0] RC_FULL  = 2'd1;
    localparam logic [CODE_W-1:0] RC_IDLE  = 2'd2;
    localparam logic [CODE_W-1:0] RC_FIRED = 2'd3;

    typedef struct packed {
        logic              capture;
        logic              add_init;
        logic              rd_head;
        logic              latch_head;
        logic              fire_wr;
        logic              latch_cand;
        logic              step;
        logic              place;
        logic              set_res;
        logic [CODE_W-1:0] code;
        logic              res_id;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic due_hit;
        logic more;
        logic move;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/pttq_in_if.sv
// Request channel of the timer queue: valid, ready and the request fields.
interface pttq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [pttq_pkg::PERIOD_W-1:0] period_ms;

    modport source (output valid, output kind, output period_ms, input ready);
    modport sink   (input valid, input kind, input period_ms, output ready);
endinterface

FILE: rtl/pttq_out_if.sv
// Result channel of the timer queue: valid, ready and the result fields.
interface pttq_out_if;
    logic                        valid;
    logic                        ready;
    logic [pttq_pkg::CODE_W-1:0] result_code;
    logic [pttq_pkg::TID_W-1:0]  task_id;

    modport source (output valid, output result_code, output task_id, input ready);
    modport sink   (input valid, input result_code, input task_id, output ready);
endinterface

FILE: rtl/pttq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pttq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pttq_ctrl.sv
// Controller state machine that sequences adds, ticks and the sorted reinsertion.
module pttq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output pttq_pkg::t_cmd o_cmd,
    input  pttq_pkg::t_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_HEAD   = 3'd2;
    localparam logic [2:0] S_DUE    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_RDORD  = 3'd5;
    localparam logic [2:0] S_CMP    = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_add) begin
                    if (i_sts.full) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.code    = pttq_pkg::RC_FULL;
                        n_state       = S_RESULT;
                    end else begin
                        o_cmd.add_init = 1'b1;
                        n_state        = S_SCAN;
                    end
                end else if (i_sts.empty) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.code    = pttq_pkg::RC_IDLE;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.latch_head = 1'b1;
                n_state          = S_DUE;
            end
            S_DUE: begin
                o_cmd.set_res = 1'b1;
                if (i_sts.due_hit) begin
                    o_cmd.fire_wr = 1'b1;
                    o_cmd.code    = pttq_pkg::RC_FIRED;
                    o_cmd.res_id  = 1'b1;
                    n_state       = S_SCAN;
                end else begin
                    o_cmd.code = pttq_pkg::RC_IDLE;
                    n_state    = S_RESULT;
                end
            end
            S_SCAN: begin
                if (i_sts.more) begin
                    n_state = S_RDORD;
                end else begin
                    o_cmd.place = 1'b1;
                    if (i_sts.is_add) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.code    = pttq_pkg::RC_ADDED;
                        o_cmd.res_id  = 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            S_RDORD: begin
                o_cmd.latch_cand = 1'b1;
                n_state          = S_CMP;
            end
            S_CMP: begin
                if (i_sts.move) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    o_cmd.place = 1'b1;
                    if (i_sts.is_add) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.code    = pttq_pkg::RC_ADDED;
                        o_cmd.res_id  = 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/pttq_dp.sv
// Datapath: tick and task counters, task and order RAMs, scan registers and result register.
module pttq_dp #(
    parameter int MAX_TASKS = pttq_pkg::MAX_TASKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pttq_pkg::t_cmd                i_cmd,
    output pttq_pkg::t_sts                o_sts,
    input  logic                          i_kind,
    input  logic [pttq_pkg::PERIOD_W-1:0] i_period_ms,
    pttq_out_if.source                    o_out
);

    localparam int ID_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int TW    = pttq_pkg::TIME_W;
    localparam int PW    = pttq_pkg::PERIOD_W;

    logic [TW-1:0]                 r_tick;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_kind;
    logic [PW-1:0]                 r_period;
    logic [ID_W-1:0]               r_pos;
    logic [ID_W-1:0]               r_moving;
    logic [ID_W-1:0]               r_cand;
    logic [TW-1:0]                 r_key;
    logic [pttq_pkg::CODE_W-1:0]   r_code;
    logic [ID_W-1:0]               r_id;
    logic                          r_ovalid;
    logic [pttq_pkg::CODE_W-1:0]   r_ocode;
    logic [pttq_pkg::TID_W-1:0]    r_otid;
    logic [pttq_pkg::TID_W-1:0]    w_tid;

    logic [TW-1:0]      w_p32;
    logic [TW-1:0]      w_scaled;
    logic               tab_we;
    logic [ID_W-1:0]    tab_waddr;
    logic [2*TW-1:0]    tab_wdata;
    logic [2*TW-1:0]    tab_rdata;
    logic [TW-1:0]      w_due;
    logic [TW-1:0]      w_per;
    logic [TW-1:0]      w_sum;
    logic               ord_we;
    logic [ID_W-1:0]    ord_wdata;
    logic [ID_W-1:0]    ord_raddr;
    logic [ID_W-1:0]    ord_rdata;

    assign w_p32    = {{(TW - PW){1'b0}}, r_period};
    assign w_scaled = w_p32 * TW'(pttq_pkg::PERIOD_SCALE);
    assign w_due    = tab_rdata[TW-1:0];
    assign w_per    = tab_rdata[2*TW-1:TW];
    assign w_sum    = w_due + w_per;

    assign tab_we    = i_cmd.add_init | i_cmd.fire_wr;
    assign tab_waddr = i_cmd.add_init ? r_cnt[ID_W-1:0] : r_moving;
    assign tab_wdata = i_cmd.add_init ? {w_scaled, w_scaled} : {w_per, w_sum};

    assign ord_we    = i_cmd.step | i_cmd.place;
    assign ord_wdata = i_cmd.step ? r_cand : r_moving;
    assign ord_raddr = i_cmd.rd_head ? '0 : (r_kind ? r_pos - 1'b1 : r_pos + 1'b1);

    pttq_ram #(.WIDTH(2 * TW), .DEPTH(MAX_TASKS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (ord_rdata),
        .o_rdata (tab_rdata)
    );

    pttq_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_ord (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_pos),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.capture && !i_kind) begin
                r_tick <= r_tick + 1'b1;
            end
            if (i_cmd.place && r_kind) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_period <= i_period_ms;
        end
        if (i_cmd.add_init) begin
            r_moving <= r_cnt[ID_W-1:0];
            r_pos    <= r_cnt[ID_W-1:0];
            r_key    <= w_scaled;
        end
        if (i_cmd.latch_head) begin
            r_moving <= ord_rdata;
        end
        if (i_cmd.fire_wr) begin
            r_key <= w_sum;
            r_pos <= '0;
        end
        if (i_cmd.latch_cand) begin
            r_cand <= ord_rdata;
        end
        if (i_cmd.step) begin
            r_pos <= r_kind ? r_pos - 1'b1 : r_pos + 1'b1;
        end
        if (i_cmd.set_res) begin
            r_code <= i_cmd.code;
            r_id   <= i_cmd.res_id ? r_moving : '0;
        end
        if (i_cmd.out_load) begin
            r_ocode <= r_code;
            r_otid  <= w_tid;
        end
    end

    generate
        if (ID_W >= pttq_pkg::TID_W) begin : g_tid_cut
            assign w_tid = r_id[pttq_pkg::TID_W-1:0];
        end else begin : g_tid_ext
            assign w_tid = {{(pttq_pkg::TID_W - ID_W){1'b0}}, r_id};
        end
    endgenerate

    assign o_sts.is_add   = r_kind;
    assign o_sts.full     = (r_cnt >= CNT_W'(MAX_TASKS));
    assign o_sts.empty    = (r_cnt == '0);
    assign o_sts.due_hit  = (r_tick > w_due);
    assign o_sts.more     = r_kind ? (r_pos != '0) : ((CNT_W'(r_pos) + 1'b1) < r_cnt);
    assign o_sts.move     = r_kind ? (w_due >= r_key) : (w_due < r_key);
    assign o_sts.out_free = !r_ovalid || o_out.ready;

    assign o_out.valid       = r_ovalid;
    assign o_out.result_code = r_ocode;
    assign o_out.task_id     = r_otid;

endmodule

FILE: rtl/periodic_task_timer_queue_unit.sv
// Top level of the periodic task timer queue: controller, datapath and checks.
//
//   channel  direction  beat fields
//   i_in     in         kind, period_ms
//   o_out    out        result_code, task_id
//
// Each beat is handled alone. An add to a full table, a tick on an empty table and a tick
// with nothing due give their result without a scan. An add and a firing tick move their
// task entry by entry, each scan step made of the two registered RAM reads (order, then
// task table) and a compare of the stored due time against the moving task's key.
// Reset clears the tick and task counts and the result valid; the RAMs need no clearing pass.
// A result waits in the output register while the next beat is taken; only the
// hand-off of a new result stalls behind a result not yet taken.
module periodic_task_timer_queue_unit #(
    parameter int MAX_TASKS = pttq_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pttq_in_if.sink     i_in,
    pttq_out_if.source  o_out
);

    pttq_pkg::t_cmd cmd;
    pttq_pkg::t_sts sts;

    pttq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    pttq_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_in.kind),
        .i_period_ms (i_in.period_ms),
        .o_out       (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over a waiting result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("new beat taken while one is in work");

    a_fire_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fire_wr |-> (sts.due_hit && !sts.is_add))
        else $error("due time updated without a due tick");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step || cmd.place || cmd.latch_cand) |-> !i_in.ready)
        else $error("scan active while request port is ready");

endmodule
